@@ sv/nfcd_pkg.sv @@
// ----------------------------------------------------------------------------
// nfcd_pkg
// Shared types and constants for the NFC host response deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcd_pkg;

	// Largest number of response bytes ever delivered for one read
	localparam int MAX_PAYLOAD = 40;
	localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

	// Configuration register indexes
	localparam logic CFG_EXPECTED_CMD = 1'b0;
	localparam logic CFG_OUT_CAPACITY = 1'b1;

	// Configuration reset values
	localparam logic [7:0] EXPECTED_CMD_RST = 8'd74;
	localparam logic [5:0] OUT_CAPACITY_RST = 6'd24;

	// Frame constants
	localparam logic [7:0] PREAMBLE_ZERO = 8'h00;
	localparam logic [7:0] START_CODE    = 8'hFF;
	localparam logic [7:0] DIR_TO_HOST   = 8'hD5;
	localparam logic [7:0] MIN_LENGTH    = 8'd2;

	// Byte positions within a read (status byte is position zero)
	localparam logic [3:0] POS_IDLE  = 4'd0;
	localparam logic [3:0] POS_PRE0  = 4'd1;
	localparam logic [3:0] POS_PRE1  = 4'd2;
	localparam logic [3:0] POS_START = 4'd3;
	localparam logic [3:0] POS_LEN   = 4'd4;
	localparam logic [3:0] POS_LCS   = 4'd5;
	localparam logic [3:0] POS_DIR   = 4'd6;
	localparam logic [3:0] POS_CODE  = 4'd7;
	localparam logic [3:0] POS_DATA  = 4'd8;

	// Result status codes
	typedef enum logic [2:0] {
		ST_DATA     = 3'd0,
		ST_PREAMBLE = 3'd1,
		ST_SHORT    = 3'd2,
		ST_LCS      = 3'd3,
		ST_DIR      = 3'd4,
		ST_CODE     = 3'd5
	} status_t;

	// One result transaction
	typedef struct packed {
		logic [7:0] data;
		status_t    status;
		logic       last;
		logic [5:0] count;
	} result_t;

endpackage

`default_nettype wire

@@ sv/nfcd_parser.sv @@
// ----------------------------------------------------------------------------
// nfcd_parser
// Input register, configuration registers and the per-byte frame checks.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcd_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              frame_start,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              buf_full,
	output logic                   res_push,
	output nfcd_pkg::result_t      res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        go;

	logic [7:0]  cmd_q;
	logic [5:0]  cap_q;

	logic [3:0]  pos_q, pos_d;
	logic [7:0]  len_q, len_d;
	logic [5:0]  left_q, left_d;
	logic [5:0]  cnt_q, cnt_d;
	logic        fin_q, fin_d;

	logic [7:0]  code_exp;
	logic [7:0]  lcs_sum;
	logic [5:0]  cap_eff;
	logic [7:0]  n_full;
	logic [5:0]  left_new;
	logic [5:0]  cnt_inc;

	// Input register; the byte moves on whenever the result buffer has room
	assign go       = valid_s1 && !buf_full;
	assign in_stall = valid_s1 && buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= nfcd_pkg::EXPECTED_CMD_RST;
			cap_q <= nfcd_pkg::OUT_CAPACITY_RST;
		end else if (cfg_we) begin
			if (cfg_index == nfcd_pkg::CFG_EXPECTED_CMD) begin
				cmd_q <= cfg_data;
			end else begin
				cap_q <= cfg_data[5:0];
			end
		end
	end

	// Derived values for the header checks and the delivery count
	assign code_exp = cmd_q + 8'd1;
	assign lcs_sum  = len_q + byte_s1;
	assign cnt_inc  = cnt_q + 6'd1;

	always_comb begin
		cap_eff = (cap_q == 6'd0) ? 6'd1 : cap_q;
		if ({2'b00, cap_eff} > nfcd_pkg::MAX_PAYLOAD_B) begin
			cap_eff = nfcd_pkg::MAX_PAYLOAD_B[5:0];
		end
		n_full = len_q - 8'd1;
		if (n_full > {2'b00, cap_eff}) begin
			n_full = {2'b00, cap_eff};
		end
		left_new = n_full[5:0] - 6'd1;
	end

	// Frame walk: one byte per transaction
	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		left_d   = left_q;
		cnt_d    = cnt_q;
		fin_d    = fin_q;
		res_push = 1'b0;
		res      = '0;
		res.status = nfcd_pkg::ST_DATA;

		if (go) begin
			if (start_s1) begin
				// Status byte: restart the read, dropping any frame in flight
				pos_d  = nfcd_pkg::POS_PRE0;
				len_d  = 8'd0;
				left_d = 6'd0;
				cnt_d  = 6'd0;
				fin_d  = 1'b0;
			end else if (!fin_q) begin
				case (pos_q)
					nfcd_pkg::POS_PRE0, nfcd_pkg::POS_PRE1: begin
						if (byte_s1 != nfcd_pkg::PREAMBLE_ZERO) begin
							fin_d      = 1'b1;
							res_push   = 1'b1;
							res.status = nfcd_pkg::ST_PREAMBLE;
							res.last   = 1'b1;
						end else begin
							pos_d = pos_q + 4'd1;
						end
					end
					nfcd_pkg::POS_START: begin
						if (byte_s1 != nfcd_pkg::START_CODE) begin
							fin_d      = 1'b1;
							res_push   = 1'b1;
							res.status = nfcd_pkg::ST_PREAMBLE;
							res.last   = 1'b1;
						end else begin
							pos_d = nfcd_pkg::POS_LEN;
						end
					end
					nfcd_pkg::POS_LEN: begin
						len_d = byte_s1;
						if (byte_s1 < nfcd_pkg::MIN_LENGTH) begin
							fin_d      = 1'b1;
							res_push   = 1'b1;
							res.status = nfcd_pkg::ST_SHORT;
							res.last   = 1'b1;
						end else begin
							pos_d = nfcd_pkg::POS_LCS;
						end
					end
					nfcd_pkg::POS_LCS: begin
						if (lcs_sum != 8'd0) begin
							fin_d      = 1'b1;
							res_push   = 1'b1;
							res.status = nfcd_pkg::ST_LCS;
							res.last   = 1'b1;
						end else begin
							pos_d = nfcd_pkg::POS_DIR;
						end
					end
					nfcd_pkg::POS_DIR: begin
						if (byte_s1 != nfcd_pkg::DIR_TO_HOST) begin
							fin_d      = 1'b1;
							res_push   = 1'b1;
							res.status = nfcd_pkg::ST_DIR;
							res.last   = 1'b1;
						end else begin
							pos_d = nfcd_pkg::POS_CODE;
						end
					end
					nfcd_pkg::POS_CODE: begin
						res_push = 1'b1;
						if (byte_s1 != code_exp) begin
							fin_d      = 1'b1;
							res.status = nfcd_pkg::ST_CODE;
							res.last   = 1'b1;
						end else begin
							// Response code is the first delivered byte
							pos_d    = nfcd_pkg::POS_DATA;
							cnt_d    = 6'd1;
							res.data = byte_s1;
							if (left_new == 6'd0) begin
								fin_d     = 1'b1;
								left_d    = 6'd0;
								res.last  = 1'b1;
								res.count = 6'd1;
							end else begin
								left_d = left_new - 6'd1;
							end
						end
					end
					nfcd_pkg::POS_DATA: begin
						res_push = 1'b1;
						cnt_d    = cnt_inc;
						res.data = byte_s1;
						if (left_q == 6'd0) begin
							fin_d     = 1'b1;
							res.last  = 1'b1;
							res.count = cnt_inc;
						end else begin
							left_d = left_q - 6'd1;
						end
					end
					default: begin
						fin_d = 1'b1;
					end
				endcase
			end
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= nfcd_pkg::POS_IDLE;
			len_q  <= 8'd0;
			left_q <= 6'd0;
			cnt_q  <= 6'd0;
			fin_q  <= 1'b1;
		end else begin
			pos_q  <= pos_d;
			len_q  <= len_d;
			left_q <= left_d;
			cnt_q  <= cnt_d;
			fin_q  <= fin_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/nfcd_outbuf.sv @@
// ----------------------------------------------------------------------------
// nfcd_outbuf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcd_outbuf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire nfcd_pkg::result_t  din,
	output logic                    full,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output nfcd_pkg::result_t       dout
);

	logic [1:0]        cnt_q;
	nfcd_pkg::result_t head_q;
	nfcd_pkg::result_t skid_q;
	logic              pop;

	assign pop       = out_valid && !out_stall;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign dout      = head_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Payload: head is presented, skid catches a result while head waits
	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= din;
				end else begin
					skid_q <= din;
				end
			end
			2'b01: begin
				head_q <= skid_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= din;
				end else begin
					head_q <= skid_q;
					skid_q <= din;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/nfc_host_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// nfc_host_frame_deframer
// Checks an NFC controller response frame and delivers the response bytes.
// ----------------------------------------------------------------------------
// Path: an accepted byte is registered, checked, and its result registered
// into the output buffer. Throughput: one byte per cycle unless the buffer is
// full; two entries keep input flowing while one result waits at a stalled
// output. Reset: asynchronous, active low; registers return to their defaults and
// the block ignores bytes until a frame start.
`default_nettype none

module nfc_host_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_byte,
	output logic [2:0]       status,
	output logic             last,
	output logic [5:0]       data_count,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	nfcd_pkg::result_t res;
	nfcd_pkg::result_t dout;
	logic              res_push;
	logic              buf_full;

	nfcd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.buf_full    (buf_full),
		.res_push    (res_push),
		.res         (res)
	);

	nfcd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.din       (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (dout)
	);

	// Result fields onto their ports
	assign data_byte  = dout.data;
	assign status     = dout.status;
	assign last       = dout.last;
	assign data_count = dout.count;

endmodule

`default_nettype wire

@@ tb/sv/nfcd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfcd_checker
// Watches the byte and result channels of the NFC response deframer, keeps
// its own copy of the deframing state and registers, and compares every
// result transaction field by field with the oldest predicted one.
// ----------------------------------------------------------------------------

module nfcd_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_start,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic [2:0] status,
	input  wire logic       last,
	input  wire logic [5:0] data_count,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	output int              mismatches,
	output int              pending,
	output int              bytes_seen,
	output int              results_seen,
	output int              errors_seen
);

	// Register copies
	logic [7:0] cmd_sent;
	logic [5:0] capacity;

	// Deframing state
	logic [3:0] pos;
	logic [7:0] frame_len;
	logic [5:0] remaining;
	logic [5:0] delivered;
	logic       idle;

	// Results still owed by the block, oldest first
	nfcd_pkg::result_t owed_results[$];
	nfcd_pkg::result_t want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		mismatches++;
		$display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h",
			$time, what, got, exp_val);
	endtask

	task automatic reject(input nfcd_pkg::status_t code);
		idle = 1'b1;
		owed_results.push_back({8'h00, code, 1'b1, 6'd0});
	endtask

	task automatic deliver_byte(input logic [7:0] b);
		delivered = delivered + 6'd1;
		if (remaining == 6'd0) begin
			idle = 1'b1;
			owed_results.push_back({b, nfcd_pkg::ST_DATA, 1'b1, delivered});
		end else begin
			remaining = remaining - 6'd1;
			owed_results.push_back({b, nfcd_pkg::ST_DATA, 1'b0, 6'd0});
		end
	endtask

	// Advance the deframing state by one accepted byte
	task automatic deframe_byte(input logic [7:0] b, input logic s);
		int cap;
		int n;
		if (s) begin
			pos       = nfcd_pkg::POS_PRE0;
			frame_len = 8'd0;
			remaining = 6'd0;
			delivered = 6'd0;
			idle      = 1'b0;
		end else if (!idle) begin
			case (pos)
				nfcd_pkg::POS_PRE0, nfcd_pkg::POS_PRE1: begin
					if (b != nfcd_pkg::PREAMBLE_ZERO) reject(nfcd_pkg::ST_PREAMBLE);
					else pos = pos + 4'd1;
				end
				nfcd_pkg::POS_START: begin
					if (b != nfcd_pkg::START_CODE) reject(nfcd_pkg::ST_PREAMBLE);
					else pos = pos + 4'd1;
				end
				nfcd_pkg::POS_LEN: begin
					frame_len = b;
					if (b < nfcd_pkg::MIN_LENGTH) reject(nfcd_pkg::ST_SHORT);
					else pos = pos + 4'd1;
				end
				nfcd_pkg::POS_LCS: begin
					if (8'(frame_len + b) != 8'd0) reject(nfcd_pkg::ST_LCS);
					else pos = pos + 4'd1;
				end
				nfcd_pkg::POS_DIR: begin
					if (b != nfcd_pkg::DIR_TO_HOST) reject(nfcd_pkg::ST_DIR);
					else pos = pos + 4'd1;
				end
				nfcd_pkg::POS_CODE: begin
					if (b != 8'(cmd_sent + 8'd1)) begin
						reject(nfcd_pkg::ST_CODE);
					end else begin
						// registers are taken at the response code
						cap = int'(capacity);
						if (cap == 0) cap = 1;
						if (cap > nfcd_pkg::MAX_PAYLOAD) cap = nfcd_pkg::MAX_PAYLOAD;
						n = int'(frame_len) - 1;
						if (n > cap) n = cap;
						remaining = 6'(n - 1);
						delivered = 6'd0;
						pos       = nfcd_pkg::POS_DATA;
						deliver_byte(b);
					end
				end
				nfcd_pkg::POS_DATA: deliver_byte(b);
				default: idle = 1'b1;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_sent     = nfcd_pkg::EXPECTED_CMD_RST;
			capacity     = nfcd_pkg::OUT_CAPACITY_RST;
			pos          = nfcd_pkg::POS_IDLE;
			frame_len    = 8'd0;
			remaining    = 6'd0;
			delivered    = 6'd0;
			idle         = 1'b1;
			owed_results.delete();
			mismatches   = 0;
			pending      = 0;
			bytes_seen   = 0;
			results_seen = 0;
			errors_seen  = 0;
		end else begin
			// result transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					report_mismatch("result with nothing owed, data_byte",
						32'(data_byte), 32'd0);
				end else begin
					want = owed_results.pop_front();
					if (data_byte !== want.data)
						report_mismatch("data_byte", 32'(data_byte), 32'(want.data));
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (last !== want.last)
						report_mismatch("last", 32'(last), 32'(want.last));
					if (data_count !== want.count)
						report_mismatch("data_count", 32'(data_count), 32'(want.count));
					if (want.status != nfcd_pkg::ST_DATA) errors_seen++;
				end
			end
			// register writes
			if (cfg_we) begin
				if (cfg_index == nfcd_pkg::CFG_EXPECTED_CMD) cmd_sent = cfg_data;
				else if (cfg_index == nfcd_pkg::CFG_OUT_CAPACITY) capacity = cfg_data[5:0];
			end
			// byte transaction
			if (in_valid && !in_stall) begin
				bytes_seen++;
				deframe_byte(rx_byte, frame_start);
			end
			pending = owed_results.size();
		end
	end

endmodule

@@ tb/sv/tb_nfc_host_frame_deframer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nfc_host_frame_deframer
// Drives NFC controller reads into the deframer under several register
// settings: short directed reads, then random good, faulty and cut reads with
// random idling on both sides and one long receiver hold-off. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_nfc_host_frame_deframer;

	typedef enum int {
		F_NONE,
		F_PREAMBLE,
		F_START,
		F_SHORT,
		F_LCS,
		F_DIR,
		F_CODE
	} fault_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       frame_start;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] data_byte;
	logic [2:0] status;
	logic       last;
	logic [5:0] data_count;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	int mismatches;
	int pending;
	int bytes_seen;
	int results_seen;
	int errors_seen;

	bit         gaps_on;
	bit         hold_req;
	int         hold_left;
	int         sent;
	logic [7:0] cmd_now;

	nfc_host_frame_deframer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.status      (status),
		.last        (last),
		.data_count  (data_count),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	nfcd_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.status       (status),
		.last         (last),
		.data_count   (data_count),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.bytes_seen   (bytes_seen),
		.results_seen (results_seen),
		.errors_seen  (errors_seen)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety limit on the whole run
	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: random stalls, plus a counted hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= gaps_on && ($urandom_range(0, 99) < 6);
			end
		end
	end

	// One byte transaction; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic s);
		while (gaps_on && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		rx_byte     <= b;
		frame_start <= s;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// One read: status byte, header, response code, data, checksum, postamble.
	// keep > 0 sends only the first keep bytes, so the next start cuts it.
	task automatic send_read(input int len, input fault_t fault, input int keep);
		logic [7:0] frame[$];
		logic [7:0] code;
		logic [7:0] sum;
		logic [7:0] d;
		logic [7:0] nz;
		int         n;
		code = cmd_now + 8'd1;
		nz   = 8'($urandom_range(1, 255));
		frame.push_back(8'($urandom));
		frame.push_back(nfcd_pkg::PREAMBLE_ZERO);
		frame.push_back(nfcd_pkg::PREAMBLE_ZERO);
		frame.push_back(nfcd_pkg::START_CODE);
		frame.push_back(8'(len));
		frame.push_back(8'(-len));
		frame.push_back(nfcd_pkg::DIR_TO_HOST);
		frame.push_back(code);
		sum = nfcd_pkg::DIR_TO_HOST + code;
		for (int i = 2; i < len; i++) begin
			d = 8'($urandom);
			frame.push_back(d);
			sum = sum + d;
		end
		frame.push_back(8'(8'd0 - sum));
		frame.push_back(nfcd_pkg::PREAMBLE_ZERO);
		// corrupt one header field
		case (fault)
			F_PREAMBLE: begin
				n = $urandom_range(1, 2);
				frame[n] = frame[n] ^ nz;
			end
			F_START: frame[3] = frame[3] ^ nz;
			F_SHORT: frame[4] = 8'($urandom_range(0, 1));
			F_LCS:   frame[5] = frame[5] + nz;
			F_DIR:   frame[6] = frame[6] ^ nz;
			F_CODE:  frame[7] = frame[7] ^ nz;
			default: ;
		endcase
		n = (keep > 0 && keep < frame.size()) ? keep : frame.size();
		for (int i = 0; i < n; i++)
			send_byte(frame[i], i == 0);
		sent += n;
	endtask

	// Mostly good reads of random content, some faulty, some cut short
	task automatic random_reads(input int budget);
		int     target;
		int     roll;
		int     len;
		int     keep;
		fault_t fault;
		target = sent + budget;
		while (sent < target) begin
			if ($urandom_range(0, 99) < 8)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
			len   = ($urandom_range(0, 19) == 0) ? $urandom_range(47, 255)
				: $urandom_range(2, 46);
			roll  = $urandom_range(0, 99);
			fault = F_NONE;
			keep  = 0;
			if (roll >= 90) keep = $urandom_range(2, len + 7);
			else if (roll >= 55) fault = fault_t'($urandom_range(F_PREAMBLE, F_CODE));
			send_read(len, fault, keep);
		end
	endtask

	// Stop offering bytes and wait until every owed result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_regs(input logic [7:0] cmd, input logic [7:0] cap);
		cfg_we    <= 1'b1;
		cfg_index <= nfcd_pkg::CFG_EXPECTED_CMD;
		cfg_data  <= cmd;
		@(negedge clk);
		cfg_index <= nfcd_pkg::CFG_OUT_CAPACITY;
		cfg_data  <= cap;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
		cmd_now = cmd;
	endtask

	// Stimulus
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		rx_byte     = 8'h00;
		frame_start = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = nfcd_pkg::CFG_EXPECTED_CMD;
		cfg_data    = 8'h00;
		gaps_on     = 1'b1;
		hold_req    = 1'b0;
		sent        = 0;
		cmd_now     = nfcd_pkg::EXPECTED_CMD_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset register values
		send_byte(8'hFF, 1'b0);          // dropped, no read begun yet
		send_byte(8'h00, 1'b0);
		send_read(2, F_NONE, 9);         // shortest response, then a stray byte
		send_read(2, F_PREAMBLE, 3);
		send_read(2, F_SHORT, 5);
		send_read(9, F_NONE, 3);         // cut by the next start
		random_reads(85);

		// command 00, capacity zero
		drain();
		write_regs(8'h00, 8'd0);
		random_reads(100);

		// command FF so the response code wraps to 00, capacity one, no idling
		drain();
		gaps_on = 1'b0;
		write_regs(8'hFF, 8'd1);
		random_reads(100);

		// full capacity, long response against a held-off receiver
		drain();
		gaps_on = 1'b1;
		write_regs(8'($urandom), 8'd40);
		hold_req = 1'b1;
		send_read(255, F_NONE, 60);
		random_reads(70);

		// capacity above the maximum
		drain();
		write_regs(8'($urandom), 8'd63);
		random_reads(100);

		// random command and random capacity byte
		drain();
		write_regs(8'($urandom), 8'($urandom));
		random_reads(100);

		drain();
		repeat (4) @(negedge clk);
		$display("Run covered %0d accepted bytes and %0d checked results, %0d of them errors.",
			bytes_seen, results_seen, errors_seen);
		$display("Register settings: reset values, commands 00 and FF, capacities 0, 1, 40, 63.");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
